// ----- src/wst_pkg.sv -----
// ----------------------------------------------------------------------------
// wst_pkg
// Shared types and constants for the wall sensor tracking block.
// ----------------------------------------------------------------------------
`default_nettype none

package wst_pkg;

  localparam int unsigned AdcBits      = 10;
  localparam int unsigned GainFracBits = 8;
  localparam int unsigned GainIntBits  = 4;
  localparam int unsigned GainW        = GainIntBits + GainFracBits;
  localparam int unsigned LevelW       = 14;
  localparam int unsigned ErrOutW      = 16;
  localparam int unsigned CfgIdxW      = 4;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned FrontClose   = 100;

  typedef logic [AdcBits-1:0]  adc_t;
  typedef logic [GainW-1:0]    gain_t;
  typedef logic [LevelW-1:0]   level_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegRightGain   = 4'd0,
    RegFrontGain   = 4'd1,
    RegLeftGain    = 4'd2,
    RegRightLimit  = 4'd3,
    RegFrontLimit  = 4'd4,
    RegLeftLimit   = 4'd5,
    RegRightCentre = 4'd6,
    RegLeftCentre  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic sensors_on;
    adc_t right_dark;
    adc_t right_lit;
    adc_t front_dark;
    adc_t front_lit;
    adc_t left_dark;
    adc_t left_lit;
  } meas_t;

  typedef struct packed {
    logic signed [ErrOutW-1:0] track_error;
    logic                      left_wall;
    logic                      front_wall;
    logic                      right_wall;
    level_t                    right_level;
    level_t                    front_level;
    level_t                    left_level;
  } result_t;

endpackage : wst_pkg

`default_nettype wire

// ----- src/wst_intf.sv -----
// ----------------------------------------------------------------------------
// wst_intf
// Valid/ready channels for measurements, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wst_meas_if;
  logic            valid;
  logic            ready;
  wst_pkg::meas_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : wst_meas_if

interface wst_result_if;
  logic             valid;
  logic             ready;
  wst_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : wst_result_if

interface wst_cfg_if;
  logic               valid;
  logic               ready;
  wst_pkg::cfg_idx_t  index;
  wst_pkg::cfg_data_t wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface : wst_cfg_if

`default_nettype wire

// ----- src/wall_sensor_tracking.sv -----
// ----------------------------------------------------------------------------
// wall_sensor_tracking
// Normalizes three reflective sensor readings, sets wall flags and forms
// the cross-track error.
//
//   channel  dir  transfer when         carries
//   meas_i   in   valid & ready         sensors_on, dark/lit readings
//   res_o    out  valid & ready         track_error, wall flags, levels
//   cfg_i    in   valid & ready         register index, write data
//
// Path: measurement register, then result register.
// One transfer per cycle sustained while res_o.ready holds; the path is one 10x12 multiply per sensor.
// A stalled result holds in the result register while one more measurement
// waits in the measurement register; meas_i.ready drops only when both full.
// Reset sets the config registers to their defaults, clears both valid flags and clears held levels/flags.
// cfg_i is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_sensor_tracking (
  input  wire         clk_i,
  input  wire         rst_ni,
  wst_meas_if.sink    meas_i,
  wst_result_if.source res_o,
  wst_cfg_if.sink     cfg_i
);
  import wst_pkg::*;

  localparam int unsigned ProdW = AdcBits + GainW;
  localparam int unsigned DevW  = LevelW + 1;
  localparam int unsigned ErrW  = DevW + 2;

  localparam logic [ProdW-1:0]       LevelMaxP = ProdW'((1 << LevelW) - 1);
  localparam logic signed [ErrW-1:0] ErrMax    = ErrW'((1 << (ErrOutW - 1)) - 1);
  localparam logic signed [ErrW-1:0] ErrMin    = -ErrW'(1 << (ErrOutW - 1));

  gain_t  right_gain_q, front_gain_q, left_gain_q;
  level_t right_limit_q, front_limit_q, left_limit_q;
  level_t right_centre_q, left_centre_q;

  meas_t   meas_q;
  logic    meas_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  level_t  held_rl_q, held_fl_q, held_ll_q;
  logic    held_rw_q, held_fw_q, held_lw_q;

  logic    meas_adv;
  logic    res_free;

  function automatic level_t norm_level(adc_t dark, adc_t lit, gain_t gain);
    logic [AdcBits-1:0] diff;
    logic [ProdW-1:0]   prod;
    logic [ProdW-1:0]   scaled;
    diff   = (lit > dark) ? (lit - dark) : '0;
    prod   = ProdW'(diff) * ProdW'(gain);
    scaled = prod >> GainFracBits;
    return (scaled > LevelMaxP) ? '1 : scaled[LevelW-1:0];
  endfunction

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_gain_q   <= GainW'(1 << GainFracBits);
      front_gain_q   <= GainW'(1 << GainFracBits);
      left_gain_q    <= GainW'(1 << GainFracBits);
      right_limit_q  <= LevelW'(40);
      front_limit_q  <= LevelW'(20);
      left_limit_q   <= LevelW'(40);
      right_centre_q <= LevelW'(100);
      left_centre_q  <= LevelW'(100);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegRightGain:   right_gain_q   <= cfg_i.wdata[GainW-1:0];
        RegFrontGain:   front_gain_q   <= cfg_i.wdata[GainW-1:0];
        RegLeftGain:    left_gain_q    <= cfg_i.wdata[GainW-1:0];
        RegRightLimit:  right_limit_q  <= cfg_i.wdata[LevelW-1:0];
        RegFrontLimit:  front_limit_q  <= cfg_i.wdata[LevelW-1:0];
        RegLeftLimit:   left_limit_q   <= cfg_i.wdata[LevelW-1:0];
        RegRightCentre: right_centre_q <= cfg_i.wdata[LevelW-1:0];
        RegLeftCentre:  left_centre_q  <= cfg_i.wdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign res_free     = !res_vld_q || res_o.ready;
  assign meas_adv     = meas_vld_q && res_free;
  assign meas_i.ready = !meas_vld_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (meas_i.ready) begin
        meas_vld_q <= meas_i.valid;
      end
      if (res_free) begin
        res_vld_q <= meas_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas_i.valid && meas_i.ready) begin
      meas_q <= meas_i.data;
    end
    if (meas_adv) begin
      res_q <= res_d;
    end
  end

  // level, flag and error logic
  level_t rl, fl, ll;
  logic   rw, fw, lw;
  logic signed [DevW-1:0] rdev, ldev;
  logic signed [ErrW-1:0] err;

  always_comb begin
    rl   = norm_level(meas_q.right_dark, meas_q.right_lit, right_gain_q);
    fl   = norm_level(meas_q.front_dark, meas_q.front_lit, front_gain_q);
    ll   = norm_level(meas_q.left_dark, meas_q.left_lit, left_gain_q);
    rw   = rl > right_limit_q;
    fw   = fl > front_limit_q;
    lw   = ll > left_limit_q;
    rdev = $signed({1'b0, right_centre_q}) - $signed({1'b0, rl});
    ldev = $signed({1'b0, left_centre_q}) - $signed({1'b0, ll});
    err  = '0;
    if (lw && rw) begin
      err = ErrW'(ldev) - ErrW'(rdev);
    end else if (lw) begin
      err = ErrW'(ldev) <<< 1;
    end else if (rw) begin
      err = -(ErrW'(rdev) <<< 1);
    end
    if (fl > LevelW'(FrontClose)) begin
      err = '0;
    end
    if (err > ErrMax) begin
      err = ErrMax;
    end else if (err < ErrMin) begin
      err = ErrMin;
    end

    if (meas_q.sensors_on) begin
      res_d.track_error = err[ErrOutW-1:0];
      res_d.left_wall   = lw;
      res_d.front_wall  = fw;
      res_d.right_wall  = rw;
      res_d.right_level = rl;
      res_d.front_level = fl;
      res_d.left_level  = ll;
    end else begin
      res_d.track_error = '0;
      res_d.left_wall   = held_lw_q;
      res_d.front_wall  = held_fw_q;
      res_d.right_wall  = held_rw_q;
      res_d.right_level = held_rl_q;
      res_d.front_level = held_fl_q;
      res_d.left_level  = held_ll_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_rl_q <= '0;
      held_fl_q <= '0;
      held_ll_q <= '0;
      held_rw_q <= 1'b0;
      held_fw_q <= 1'b0;
      held_lw_q <= 1'b0;
    end else if (meas_adv && meas_q.sensors_on) begin
      held_rl_q <= rl;
      held_fl_q <= fl;
      held_ll_q <= ll;
      held_rw_q <= rw;
      held_fw_q <= fw;
      held_lw_q <= lw;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  // checks
  a_off_zero_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_adv && !meas_q.sensors_on |=> res_vld_q && res_q.track_error == '0)
    else $error("sensing off must give zero error");

  a_off_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_adv && !meas_q.sensors_on |=>
      $stable(held_rl_q) && $stable(held_fl_q) && $stable(held_ll_q))
    else $error("held levels changed while sensing off");

  a_front_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.track_error != '0 |-> res_q.front_level <= LevelW'(FrontClose))
    else $error("nonzero error with close front wall");

  a_no_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_q.left_wall && !res_q.right_wall |-> res_q.track_error == '0)
    else $error("nonzero error without side walls");

  a_held_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_adv && meas_q.sensors_on |=>
      res_q.right_level == held_rl_q && res_q.left_wall == held_lw_q)
    else $error("held state does not match reported result");

endmodule : wall_sensor_tracking

`default_nettype wire

// ----- bench/wst_checker.sv -----
// ----------------------------------------------------------------------------
// wst_checker
// Watches the measurement, register and result channels of the wall sensor
// tracking block. It keeps its own copy of the gains, limits, centres and
// held levels, predicts the result of every measurement transfer, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wst_checker (
  input  wire   clk_i,
  input  wire   rst_ni,
  wst_meas_if   meas_i,
  wst_result_if res_i,
  wst_cfg_if    cfg_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wst_pkg::*;

  localparam int unsigned ProdW    = AdcBits + GainW;
  localparam int unsigned LevelMax = (1 << LevelW) - 1;
  localparam int          ErrMax   = (1 << (ErrOutW - 1)) - 1;
  localparam int          ErrMin   = -(1 << (ErrOutW - 1));
  localparam int unsigned GainOne  = 1 << GainFracBits;

  gain_t   gain_r, gain_f, gain_l;
  level_t  limit_r, limit_f, limit_l;
  level_t  centre_r, centre_l;
  level_t  lvl_r, lvl_f, lvl_l;
  logic    wall_r, wall_f, wall_l;
  result_t expected_results [$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  task automatic load_defaults();
    gain_r   = gain_t'(GainOne);
    gain_f   = gain_t'(GainOne);
    gain_l   = gain_t'(GainOne);
    limit_r  = level_t'(40);
    limit_f  = level_t'(20);
    limit_l  = level_t'(40);
    centre_r = level_t'(100);
    centre_l = level_t'(100);
    lvl_r    = '0;
    lvl_f    = '0;
    lvl_l    = '0;
    wall_r   = 1'b0;
    wall_f   = 1'b0;
    wall_l   = 1'b0;
  endtask

  task automatic apply_write(cfg_idx_t idx, cfg_data_t wdata);
    case (idx)
      RegRightGain:   gain_r   = gain_t'(wdata);
      RegFrontGain:   gain_f   = gain_t'(wdata);
      RegLeftGain:    gain_l   = gain_t'(wdata);
      RegRightLimit:  limit_r  = level_t'(wdata);
      RegFrontLimit:  limit_f  = level_t'(wdata);
      RegLeftLimit:   limit_l  = level_t'(wdata);
      RegRightCentre: centre_r = level_t'(wdata);
      RegLeftCentre:  centre_l = level_t'(wdata);
      default: ;
    endcase
  endtask

  function automatic level_t scaled_level(adc_t dark, adc_t lit, gain_t gain);
    logic [ProdW-1:0] product;
    logic [ProdW-1:0] scaled;
    adc_t             diff;
    diff    = (lit > dark) ? adc_t'(lit - dark) : '0;
    product = ProdW'(diff) * ProdW'(gain);
    scaled  = product >> GainFracBits;
    return (scaled > ProdW'(LevelMax)) ? level_t'(LevelMax) : level_t'(scaled);
  endfunction

  // Updates the held levels and flags as a side effect when sensing is on.
  function automatic result_t predict_tracking(meas_t m);
    result_t r;
    int      rdev;
    int      ldev;
    int      err;
    err = 0;
    if (m.sensors_on) begin
      lvl_r  = scaled_level(m.right_dark, m.right_lit, gain_r);
      lvl_f  = scaled_level(m.front_dark, m.front_lit, gain_f);
      lvl_l  = scaled_level(m.left_dark, m.left_lit, gain_l);
      wall_r = lvl_r > limit_r;
      wall_f = lvl_f > limit_f;
      wall_l = lvl_l > limit_l;
      rdev   = int'(centre_r) - int'(lvl_r);
      ldev   = int'(centre_l) - int'(lvl_l);
      if (wall_l && wall_r) begin
        err = ldev - rdev;
      end else if (wall_l) begin
        err = 2 * ldev;
      end else if (wall_r) begin
        err = -2 * rdev;
      end
      if (lvl_f > LevelW'(FrontClose)) begin
        err = 0;
      end
      if (err > ErrMax) err = ErrMax;
      if (err < ErrMin) err = ErrMin;
    end
    r.track_error = ErrOutW'(err);
    r.left_wall   = wall_l;
    r.front_wall  = wall_f;
    r.right_wall  = wall_r;
    r.right_level = lvl_r;
    r.front_level = lvl_f;
    r.left_level  = lvl_l;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      load_defaults();
      expected_results.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no result expected");
        end else begin
          want = expected_results.pop_front();
          check_field("track_error", res_i.data.track_error, want.track_error);
          check_field("left_wall", res_i.data.left_wall, want.left_wall);
          check_field("front_wall", res_i.data.front_wall, want.front_wall);
          check_field("right_wall", res_i.data.right_wall, want.right_wall);
          check_field("right_level", res_i.data.right_level, want.right_level);
          check_field("front_level", res_i.data.front_level, want.front_level);
          check_field("left_level", res_i.data.left_level, want.left_level);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        apply_write(cfg_i.index, cfg_i.wdata);
      end
      if (meas_i.valid && meas_i.ready) begin
        expected_results.push_back(predict_tracking(meas_i.data));
      end
    end
    pending_o = expected_results.size();
  end

endmodule : wst_checker

// ----- bench/wall_sensor_tracking_tb.sv -----
// ----------------------------------------------------------------------------
// wall_sensor_tracking_tb
// Drives measurements and register writes into the wall sensor tracking
// block with random gaps on the measurement side and random stalls on the
// result side. A directed run covers zero, full-scale and clamped readings,
// sensing off, wall thresholds, the close front wall and error extremes;
// random phases follow with fresh register settings. The checker compares
// every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module wall_sensor_tracking_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wst_pkg::*;

  localparam int unsigned MaxWait       = 18;
  localparam int unsigned RandomPhases  = 10;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned ExtremeItems  = 30;
  localparam int unsigned NumRegs       = 8;
  localparam int unsigned GainMax       = (1 << GainW) - 1;
  localparam int unsigned LevelMax      = (1 << LevelW) - 1;
  localparam adc_t        AdcMax        = '1;
  localparam cfg_idx_t    LastIdx       = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fails;
  int   pending;
  bit   meas_burst;
  bit   res_burst;

  always #6 clk = ~clk;

  wst_meas_if   meas_if ();
  wst_result_if res_if ();
  wst_cfg_if    cfg_if ();

  wall_sensor_tracking u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .meas_i (meas_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  wst_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .meas_i       (meas_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // Occasionally switch into or out of a run with no idle cycles.
  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 29) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MaxWait);
  endfunction

  function automatic int unsigned pick(int unsigned lo, int unsigned hi,
                                       int unsigned full);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, full) : $urandom_range(lo, hi);
  endfunction

  function automatic meas_t mk(logic on, int unsigned rd, int unsigned rl,
                               int unsigned fd, int unsigned fl,
                               int unsigned ld, int unsigned ll);
    meas_t m;
    m.sensors_on = on;
    m.right_dark = adc_t'(rd);
    m.right_lit  = adc_t'(rl);
    m.front_dark = adc_t'(fd);
    m.front_lit  = adc_t'(fl);
    m.left_dark  = adc_t'(ld);
    m.left_lit   = adc_t'(ll);
    return m;
  endfunction

  // Mostly a lit reading a little above dark, so levels sit near the limits.
  function automatic adc_t shaped_lit(adc_t dark, adc_t lit, int unsigned span);
    int unsigned sum;
    if ($urandom_range(0, 3) == 0) return lit;
    sum = dark + $urandom_range(0, span);
    return (sum > AdcMax) ? AdcMax : adc_t'(sum);
  endfunction

  function automatic meas_t rand_meas();
    logic [63:0] raw;
    meas_t       m;
    raw          = {$urandom, $urandom};
    m            = raw[$bits(meas_t)-1:0];
    m.sensors_on = ($urandom_range(0, 7) != 0);
    m.right_lit  = shaped_lit(m.right_dark, m.right_lit, 300);
    m.front_lit  = shaped_lit(m.front_dark, m.front_lit, 120);
    m.left_lit   = shaped_lit(m.left_dark, m.left_lit, 300);
    return m;
  endfunction

  task automatic send_meas(meas_t m);
    int unsigned gap;
    gap = draw_wait(meas_burst);
    if (gap > 0) begin
      meas_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas_if.valid <= 1'b1;
    meas_if.data  <= m;
    @(posedge clk);
    while (!meas_if.ready) @(posedge clk);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_meas(rand_meas());
  endtask

  task automatic drain();
    meas_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Bits above the register width carry noise; the block must ignore them.
  task automatic write_reg(cfg_idx_t idx, cfg_data_t value, int unsigned width);
    cfg_data_t noise;
    noise = cfg_data_t'($urandom);
    noise = (noise >> width) << width;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= noise | value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic set_config(int unsigned gr, int unsigned gf, int unsigned gl,
                            int unsigned lr, int unsigned lf, int unsigned ll,
                            int unsigned cr, int unsigned cl);
    write_reg(RegRightGain, cfg_data_t'(gr), GainW);
    write_reg(RegFrontGain, cfg_data_t'(gf), GainW);
    write_reg(RegLeftGain, cfg_data_t'(gl), GainW);
    write_reg(RegRightLimit, cfg_data_t'(lr), LevelW);
    write_reg(RegFrontLimit, cfg_data_t'(lf), LevelW);
    write_reg(RegLeftLimit, cfg_data_t'(ll), LevelW);
    write_reg(RegRightCentre, cfg_data_t'(cr), LevelW);
    write_reg(RegLeftCentre, cfg_data_t'(cl), LevelW);
    // write to an unmapped index, must have no effect
    write_reg(cfg_idx_t'($urandom_range(NumRegs, LastIdx)), '0, 0);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait(res_burst);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  initial begin
    meas_if.valid = 1'b0;
    meas_if.data  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.wdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unit gains, limits 40/20/40, centres 100
    send_meas(mk(1'b0, 0, 0, 0, 0, 0, 0));
    send_meas(mk(1'b1, 0, 0, 0, 0, 0, 0));
    send_meas(mk(1'b1, 0, AdcMax, 0, AdcMax, 0, AdcMax));
    send_meas(mk(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    send_meas(mk(1'b1, AdcMax, 0, AdcMax, 0, AdcMax, 0));
    send_meas(mk(1'b1, 500, 500, 300, 300, 700, 700));
    send_meas(mk(1'b1, 10, 160, 5, 15, 20, 80));
    send_meas(mk(1'b1, 0, 40, 0, 20, 0, 41));
    send_meas(mk(1'b1, 0, 41, 0, 21, 0, 40));
    send_meas(mk(1'b1, 0, 150, 0, 100, 0, 80));
    send_meas(mk(1'b1, 0, 150, 0, 101, 0, 80));
    send_meas(mk(1'b0, 0, 0, 0, 0, 0, 0));
    drain();

    // full gains, left wall only, largest positive error
    set_config(GainMax, GainMax, GainMax, LevelMax, LevelMax, 0, 0, LevelMax);
    send_meas(mk(1'b1, 0, 0, 0, 0, 0, 1));
    send_meas(mk(1'b1, 0, AdcMax, 0, 0, 0, AdcMax));
    send_random(ExtremeItems);
    drain();

    // zero gains: nothing is ever a wall
    set_config(0, 0, 0, 0, 0, 0, 0, 0);
    send_meas(mk(1'b1, 0, AdcMax, 0, AdcMax, 0, AdcMax));
    send_random(ExtremeItems);
    drain();

    // full gains, right wall only, then both walls at the widest spread
    set_config(GainMax, GainMax, GainMax, 0, 0, LevelMax, LevelMax, 0);
    send_meas(mk(1'b1, 0, 1, 0, 0, 0, AdcMax));
    send_meas(mk(1'b1, 0, AdcMax, 0, 0, 0, 0));
    drain();
    set_config(GainMax, GainMax, GainMax, 0, 0, 0, 0, LevelMax);
    send_meas(mk(1'b1, 0, AdcMax, 0, 0, 0, 1));
    send_meas(mk(1'b1, 0, 1, 0, 0, 0, AdcMax));
    send_random(ExtremeItems);
    drain();

    for (int unsigned p = 0; p < RandomPhases; p++) begin
      set_config(pick(128, 640, GainMax), pick(128, 640, GainMax),
                 pick(128, 640, GainMax), pick(0, 200, LevelMax),
                 pick(0, 120, LevelMax), pick(0, 200, LevelMax),
                 pick(0, 400, LevelMax), pick(0, 400, LevelMax));
      send_random(ItemsPerPhase);
      drain();
    end

    repeat (4) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule : wall_sensor_tracking_tb

// ----- sim.f -----
src/wst_pkg.sv
src/wst_intf.sv
src/wall_sensor_tracking.sv
bench/wst_checker.sv
bench/wall_sensor_tracking_tb.sv
